// File: rtl/rcpwm_pkg.sv
// Shared types and constants for the RC PWM channel decoder.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package rcpwm_pkg;

	localparam int unsigned CH_W   = 3;
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned TICK_W = 32;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd50;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic MODE_CAPTURE = 1'b0;
	localparam logic MODE_READ    = 1'b1;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CH_W-1:0]   channel;
		logic [CAP_W-1:0]  capture_value;
		logic [TICK_W-1:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel_out;
		logic [CAP_W-1:0] pulse_width;
		logic             timed_out;
		logic             next_edge_falling;
	} res_t;

endpackage

// File: rtl/rcpwm_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on rcpwm_pkg for field widths.
interface rcpwm_in_if;
	logic                            valid;
	logic                            ready;
	logic                            mode;
	logic [rcpwm_pkg::CH_W-1:0]      channel;
	logic [rcpwm_pkg::CAP_W-1:0]     capture_value;
	logic [rcpwm_pkg::TICK_W-1:0]    now_ms;

	modport source (output valid, mode, channel, capture_value, now_ms, input ready);
	modport sink (input valid, mode, channel, capture_value, now_ms, output ready);
endinterface

interface rcpwm_out_if;
	logic                            valid;
	logic                            ready;
	logic [rcpwm_pkg::CH_W-1:0]      channel_out;
	logic [rcpwm_pkg::CAP_W-1:0]     pulse_width;
	logic                            timed_out;
	logic                            next_edge_falling;

	modport source (output valid, channel_out, pulse_width, timed_out, next_edge_falling,
		input ready);
	modport sink (input valid, channel_out, pulse_width, timed_out, next_edge_falling,
		output ready);
endinterface

// File: rtl/rcpwm_front.sv
// Front stage: accepts requests and classifies them into decoder commands.
// Depends on rcpwm_pkg and rcpwm_in_if.
module rcpwm_front #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	rcpwm_in_if.sink          in_ch,
	output logic              cmd_valid,
	output rcpwm_pkg::cmd_t   cmd,
	input  logic              cmd_ready
);

	logic              valid_s1;
	rcpwm_pkg::cmd_t   cmd_s1;
	rcpwm_pkg::op_t    op_d;
	logic [4:0]        ch_ext;
	logic              in_range;

	assign ch_ext   = {2'b00, in_ch.channel};
	assign in_range = ch_ext < 5'(CHANNELS);

	// Requests for channels that do not exist become no-ops.
	always_comb begin
		op_d = rcpwm_pkg::OP_NOP;
		if (in_range) begin
			case (in_ch.mode)
				rcpwm_pkg::MODE_CAPTURE: op_d = rcpwm_pkg::OP_CAPTURE;
				rcpwm_pkg::MODE_READ:    op_d = rcpwm_pkg::OP_READ;
				default:                 op_d = rcpwm_pkg::OP_NOP;
			endcase
		end
	end

	assign in_ch.ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1.op            <= op_d;
			cmd_s1.channel       <= in_ch.channel;
			cmd_s1.capture_value <= in_ch.capture_value;
			cmd_s1.now_ms        <= in_ch.now_ms;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

// File: rtl/rcpwm_queue.sv
// Short command queue that decouples the front stage from the channel engine.
// Depends on rcpwm_pkg for the command type and depth.
module rcpwm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rcpwm_pkg::cmd_t   in_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output rcpwm_pkg::cmd_t   out_cmd
);

	localparam int unsigned DEPTH = rcpwm_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rcpwm_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != (PTR_W+1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("command queue overfilled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue lost a push");

endmodule

// File: rtl/rcpwm_back.sv
// Channel engine: per-channel edge state, width and stamp update, timeout check.
// Depends on rcpwm_pkg and rcpwm_out_if; holds the timeout register.
module rcpwm_back #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  rcpwm_pkg::cmd_t               cmd,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcpwm_pkg::TICK_W-1:0]  timeout_ms,
	rcpwm_out_if.source                   out_ch
);

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                          edge_q   [CHANNELS];
	logic [rcpwm_pkg::CAP_W-1:0]   start_q  [CHANNELS];
	logic [rcpwm_pkg::CAP_W-1:0]   width_q  [CHANNELS];
	logic [rcpwm_pkg::TICK_W-1:0]  upd_q    [CHANNELS];
	logic [rcpwm_pkg::TICK_W-1:0]  timeout_q;

	logic                          out_valid_q;
	rcpwm_pkg::res_t               res_q;
	rcpwm_pkg::res_t               res_d;

	logic [3:0]                    ch_ext;
	logic [IDX_W-1:0]              idx;
	logic                          pop;
	logic                          edge_r;
	logic [rcpwm_pkg::CAP_W-1:0]   start_r;
	logic [rcpwm_pkg::CAP_W-1:0]   width_r;
	logic [rcpwm_pkg::TICK_W-1:0]  upd_r;
	logic [rcpwm_pkg::CAP_W-1:0]   cap_width;
	logic [rcpwm_pkg::TICK_W-1:0]  age;
	logic [rcpwm_pkg::TICK_W-1:0]  clamp;
	logic                          stale;

	assign ch_ext    = {1'b0, cmd.channel};
	assign idx       = ch_ext[IDX_W-1:0];
	assign cmd_ready = !out_valid_q || out_ch.ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;

	assign edge_r    = edge_q[idx];
	assign start_r   = start_q[idx];
	assign width_r   = width_q[idx];
	assign upd_r     = upd_q[idx];
	assign cap_width = cmd.capture_value - start_r;
	assign age       = cmd.now_ms - upd_r;
	assign clamp     = cmd.now_ms - timeout_q;
	assign stale     = !(age < timeout_q);

	always_comb begin
		res_d                   = '0;
		res_d.channel_out       = cmd.channel;
		case (cmd.op)
			rcpwm_pkg::OP_CAPTURE: begin
				if (edge_r) begin
					res_d.pulse_width       = cap_width;
					res_d.next_edge_falling = 1'b0;
				end else begin
					res_d.pulse_width       = width_r;
					res_d.next_edge_falling = 1'b1;
				end
			end
			rcpwm_pkg::OP_READ: begin
				res_d.timed_out         = stale;
				res_d.pulse_width       = stale ? '0 : width_r;
				res_d.next_edge_falling = edge_r;
			end
			default: begin
				res_d.pulse_width = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				edge_q[i]  <= 1'b0;
				start_q[i] <= '0;
				width_q[i] <= '0;
				upd_q[i]   <= '0;
			end
			timeout_q <= rcpwm_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_valid) begin
				timeout_q <= timeout_ms;
			end
			if (pop) begin
				case (cmd.op)
					rcpwm_pkg::OP_CAPTURE: begin
						if (edge_r) begin
							width_q[idx] <= cap_width;
							upd_q[idx]   <= cmd.now_ms;
							edge_q[idx]  <= 1'b0;
						end else begin
							start_q[idx] <= cmd.capture_value;
							edge_q[idx]  <= 1'b1;
						end
					end
					rcpwm_pkg::OP_READ: begin
						if (stale) begin
							upd_q[idx] <= clamp;
						end
					end
					default: begin
						edge_q[idx] <= edge_q[idx];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			out_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.channel_out       = res_q.channel_out;
	assign out_ch.pulse_width       = res_q.pulse_width;
	assign out_ch.timed_out         = res_q.timed_out;
	assign out_ch.next_edge_falling = res_q.next_edge_falling;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.timed_out) |-> res_q.pulse_width == '0)
		else $error("timed-out result carries a width");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.op == rcpwm_pkg::OP_READ && stale) |=> upd_q[$past(idx)] == $past(clamp))
		else $error("stale channel stamp not clamped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.op == rcpwm_pkg::OP_NOP)
		|=> out_valid_q && !res_q.timed_out && !res_q.next_edge_falling)
		else $error("out-of-range channel produced a non-neutral result");

endmodule

// File: rtl/rc_pwm_channel_decoder.sv
// RC PWM channel decoder, top level: front stage, command queue, channel engine.
// Depends on rcpwm_pkg, rcpwm_if, rcpwm_front, rcpwm_queue and rcpwm_back.
//
// This block decodes servo-style pulse widths for up to CHANNELS receiver
// channels. Each request on in_ch is either an edge capture (mode 0) or a
// read (mode 1) for one channel. Captures alternate rising and falling per
// channel; a falling capture stores the width (capture minus start, modulo
// 2^16) and stamps the channel with now_ms. A read returns the stored width,
// or zero with timed_out set once the channel has gone timeout_ms or more
// milliseconds without a completed pulse; the stamp is then pulled up to
// now_ms minus timeout_ms so that the channel stays stale across tick wrap.
// Requests for channels at or above CHANNELS change nothing and return a
// neutral result. Every request gives exactly one result on out_ch, in order.
// The block sustains one request per clock cycle while out_ch is ready: the
// channel engine does the read-modify-write of one channel's state for each
// command it takes, and that single update port sets the rate. A result is
// registered in the front stage, queue and engine before it is offered; a
// two-entry command queue lets input keep accepting while a result waits.
// timeout_ms is written through cfg_valid/cfg_ready (always ready), resets
// to 50, and should only be changed while no request is in flight; changing
// it does not re-examine the channels.
module rc_pwm_channel_decoder #(
	parameter int unsigned CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rcpwm_in_if.sink                      in_ch,
	rcpwm_out_if.source                   out_ch,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcpwm_pkg::TICK_W-1:0]  timeout_ms
);

	logic              front_valid;
	logic              front_ready;
	rcpwm_pkg::cmd_t   front_cmd;
	logic              back_valid;
	logic              back_ready;
	rcpwm_pkg::cmd_t   back_cmd;

	// Front stage registers each request with its classification.
	rcpwm_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (front_valid),
		.cmd       (front_cmd),
		.cmd_ready (front_ready)
	);

	// The queue lets the front keep taking requests while results stall.
	rcpwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	// The channel engine owns all per-channel state and the timeout register.
	rcpwm_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.cmd        (back_cmd),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.timeout_ms (timeout_ms),
		.out_ch     (out_ch)
	);

endmodule
